@@ design/aabb_frustum_cull_core_assert.svh @@
// Assertion macros for the frustum cull core.
// Needs no other file; the modules that assert include it by name.
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define AFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afc: same-cycle implication failed");
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afc: next-cycle implication failed");
`define AFC_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("afc: reset value check failed");
`else
`define AFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define AFC_ASSERT_RESET(lbl, clk, rst_n, cons)
`endif
`endif

@@ design/afc_pkg.sv @@
// Shared types and constants of the frustum cull core.
// No dependencies; every module of the core imports it.
`timescale 1ns / 1ps
package afc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = 64;
    localparam int COEF_W      = 16;
    localparam int EDGE_W      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int HALF_Q14    = 8192;

    localparam logic [EDGE_W-1:0] EDGE_RESET = 11'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_LEFT   = 3'd0,
        CFG_PLANE_RIGHT  = 3'd1,
        CFG_PLANE_BOTTOM = 3'd2,
        CFG_PLANE_TOP    = 3'd3,
        CFG_PLANE_NEAR   = 3'd4,
        CFG_PLANE_FAR    = 3'd5,
        CFG_CUBE_EDGE    = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [NUM_PLANES-1:0][PLANE_W-1:0] planes;
        logic [EDGE_W-1:0]                  cube_edge;
    } t_afc_cfg;

endpackage

@@ design/afc_cfg_regs.sv @@
// Configuration register file: six packed planes and the cube edge.
// Depends on afc_pkg.
`timescale 1ns / 1ps
module afc_cfg_regs
    import afc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PLANE_W-1:0]   i_cfg_data,
    output t_afc_cfg             o_cfg
);

    logic [NUM_PLANES-1:0][PLANE_W-1:0] r_planes;
    logic [EDGE_W-1:0]                  r_cube_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes    <= '0;
            r_cube_edge <= EDGE_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PLANE_LEFT:   r_planes[0] <= i_cfg_data;
                CFG_PLANE_RIGHT:  r_planes[1] <= i_cfg_data;
                CFG_PLANE_BOTTOM: r_planes[2] <= i_cfg_data;
                CFG_PLANE_TOP:    r_planes[3] <= i_cfg_data;
                CFG_PLANE_NEAR:   r_planes[4] <= i_cfg_data;
                CFG_PLANE_FAR:    r_planes[5] <= i_cfg_data;
                CFG_CUBE_EDGE:    r_cube_edge <= i_cfg_data[EDGE_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg.planes    = r_planes;
    assign o_cfg.cube_edge = r_cube_edge;

endmodule

@@ design/afc_plane_unit.sv @@
// One plane's datapath: products, partial sums and the reject compare.
// Depends on afc_pkg. Stage enables come from the top-level ready chain.
`timescale 1ns / 1ps
module afc_plane_unit
    import afc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en1,
    input  logic                     i_en2,
    input  logic [PLANE_W-1:0]       i_plane,
    input  logic [EDGE_W-1:0]        i_cube_edge,
    input  logic signed [COEF_W-1:0] i_x,
    input  logic signed [COEF_W-1:0] i_y,
    input  logic signed [COEF_W-1:0] i_z,
    output logic                     o_reject
);

    logic signed [COEF_W-1:0] w_a, w_b, w_c;
    logic [COEF_W-2:0]        w_a_pos, w_b_pos, w_c_pos;
    logic [COEF_W:0]          w_pos_sum;

    // stage 1 registers
    logic signed [31:0]       r_mx, r_my, r_mz;
    logic [27:0]              r_mk;
    logic [COEF_W-1:0]        r_d;

    // stage 2 registers
    logic signed [32:0]       r_p;
    logic signed [34:0]       r_q;

    logic signed [35:0]       w_sum;

    assign w_a = $signed(i_plane[15:0]);
    assign w_b = $signed(i_plane[31:16]);
    assign w_c = $signed(i_plane[47:32]);

    // The farthest corner along the normal adds the edge on every axis with a
    // positive coefficient; testing it alone decides all eight corners.
    assign w_a_pos   = w_a[COEF_W-1] ? '0 : w_a[COEF_W-2:0];
    assign w_b_pos   = w_b[COEF_W-1] ? '0 : w_b[COEF_W-2:0];
    assign w_c_pos   = w_c[COEF_W-1] ? '0 : w_c[COEF_W-2:0];
    assign w_pos_sum = {2'b00, w_a_pos} + {2'b00, w_b_pos} + {2'b00, w_c_pos};

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_mx <= w_a * i_x;
            r_my <= w_b * i_y;
            r_mz <= w_c * i_z;
            r_mk <= i_cube_edge * w_pos_sum;
            r_d  <= i_plane[63:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_p <= {r_mx[31], r_mx} + {r_my[31], r_my};
            r_q <= {{3{r_mz[31]}}, r_mz} + {7'b0, r_mk}
                 + {{5{r_d[COEF_W-1]}}, r_d, 14'b0};
        end
    end

    // reject when the largest distance is below minus one half
    assign w_sum    = {{3{r_p[32]}}, r_p} + {r_q[34], r_q} + 36'(HALF_Q14);
    assign o_reject = w_sum[35];

endmodule

@@ design/aabb_frustum_cull_core.sv @@
// An input transfer passes the product, partial-sum and result registers to o_out_valid.
// Throughput: one cube per cycle while the output is taken; each stage loads when it is empty or when the
// next stage moves on, so bubbles close up. Input stalls only while all three
// stages hold a cube and the output transfer is not taken.
// Reset (synchronous, active low) empties the pipeline, clears all planes
// and sets the cube edge to 16. Config writes are always taken.
`timescale 1ns / 1ps
`include "aabb_frustum_cull_core_assert.svh"
module aabb_frustum_cull_core
    import afc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [PLANE_W-1:0]       i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [COEF_W-1:0] i_corner_x,
    input  logic signed [COEF_W-1:0] i_corner_y,
    input  logic signed [COEF_W-1:0] i_corner_z,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_visible
);

    t_afc_cfg               w_cfg;
    logic [PLANE_COUNT-1:0] w_reject;
    logic                   w_rdy1, w_rdy2, w_rdy3;
    logic                   r_v1, r_v2, r_v3;
    logic                   r_visible;

    assign o_cfg_ready = 1'b1;

    afc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // a stage loads when it is empty or its contents move on
    assign w_rdy3 = !r_v3 || i_out_ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        afc_plane_unit u_plane (
            .i_clk       (i_clk),
            .i_en1       (w_rdy1),
            .i_en2       (w_rdy2),
            .i_plane     (w_cfg.planes[g]),
            .i_cube_edge (w_cfg.cube_edge),
            .i_x         (i_corner_x),
            .i_y         (i_corner_y),
            .i_z         (i_corner_z),
            .o_reject    (w_reject[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_visible <= ~|w_reject;
        end
    end

    assign o_out_valid = r_v3;
    assign o_visible   = r_visible;

    `AFC_ASSERT_IMPLY(a_full_stall_blocks, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && !i_out_ready, !o_in_ready)
    `AFC_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v1)
    `AFC_ASSERT_NEXT(a_s2_moves_on, i_clk, i_rst_n, r_v2 && w_rdy3, r_v3)
    `AFC_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, !o_out_valid)

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for aabb_frustum_cull_core: cubes against six planes and an edge size.
// Needs afc_pkg and the core RTL; visibility is predicted in-bench from the plane registers.
`timescale 1ns / 1ps
module tb_top;
    import afc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 6;
    localparam int FULL_SPAN       = -1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [PLANE_W-1:0]       i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic signed [COEF_W-1:0] i_corner_x  = '0;
    logic signed [COEF_W-1:0] i_corner_y  = '0;
    logic signed [COEF_W-1:0] i_corner_z  = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_visible;

    // Register image seen by the predictor, updated on each accepted write.
    logic [PLANE_W-1:0] plane_coef [NUM_PLANES];
    logic [EDGE_W-1:0]  edge_len;
    // Staging for the next setup to load.
    logic [PLANE_W-1:0] plan_coef [NUM_PLANES];
    logic [PLANE_W-1:0] plan_edge;

    logic visible_due[$];
    int   mismatch_count = 0;
    int   cubes_sent     = 0;
    int   results_seen   = 0;
    int   setups_loaded  = 0;
    int   cycle_count    = 0;
    bit   steady         = 1'b0;

    aabb_frustum_cull_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_corner_x  (i_corner_x),
        .i_corner_y  (i_corner_y),
        .i_corner_z  (i_corner_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_visible   (o_visible)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d results outstanding",
                     $time, CYCLE_LIMIT, visible_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // A cube is culled when some plane has all eight corners below -1/2.
    // Distances are kept scaled by 2^14, so the bound is -HALF_Q14.
    function automatic logic predict_visible(input logic signed [COEF_W-1:0] cx,
                                             input logic signed [COEF_W-1:0] cy,
                                             input logic signed [COEF_W-1:0] cz);
        longint a, b, c, d, e, px, py, pz, dist_q;
        logic   culled;
        e = longint'(edge_len);
        for (int p = 0; p < NUM_PLANES && p < PLANE_COUNT; p++) begin
            a = $signed(plane_coef[p][15:0]);
            b = $signed(plane_coef[p][31:16]);
            c = $signed(plane_coef[p][47:32]);
            d = $signed(plane_coef[p][63:48]);
            d = d * (2 * HALF_Q14);
            culled = 1'b1;
            for (int k = 0; k < 8; k++) begin
                px = longint'(cx) + (k[2] ? e : 0);
                py = longint'(cy) + (k[1] ? e : 0);
                pz = longint'(cz) + (k[0] ? e : 0);
                dist_q = a * px + b * py + c * pz + d;
                if (dist_q >= -longint'(HALF_Q14))
                    culled = 1'b0;
            end
            if (culled)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        i_out_ready <= steady || ($urandom_range(0, 99) >= 14);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (visible_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual visible=%0b",
                         $time, o_visible);
                mismatch_count++;
            end else begin
                want = visible_due.pop_front();
                if (o_visible !== want) begin
                    $display("%0t: visible mismatch, expected %0b, actual %0b",
                             $time, want, o_visible);
                    mismatch_count++;
                end
            end
        end
    end

    // Leave valid high after the transfer; settle_pipeline lowers it, and the next call may drop it for a gap.
    task automatic send_cube(input logic signed [COEF_W-1:0] cx,
                             input logic signed [COEF_W-1:0] cy,
                             input logic signed [COEF_W-1:0] cz);
        if (!steady && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_corner_x <= cx;
        i_corner_y <= cy;
        i_corner_z <= cz;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        visible_due.push_back(predict_visible(cx, cy, cz));
        cubes_sent++;
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (visible_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx < NUM_PLANES)
            plane_coef[idx] = val;
        else if (idx == CFG_CUBE_EDGE)
            edge_len = val[EDGE_W-1:0];
    endtask

    task automatic apply_setup(input bit poke_unused);
        settle_pipeline();
        for (int p = 0; p < NUM_PLANES; p++)
            write_reg(t_cfg_index'(p), plan_coef[p]);
        write_reg(CFG_CUBE_EDGE, plan_edge);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        setups_loaded++;
    endtask

    task automatic clear_plan(input logic [EDGE_W-1:0] edge_val);
        for (int p = 0; p < NUM_PLANES; p++)
            plan_coef[p] = '0;
        plan_edge = {$urandom, $urandom};
        plan_edge[EDGE_W-1:0] = edge_val;
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coord(input int span);
        if (span < 0)
            return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // All planes zero after reset, so every cube must come back visible.
    task automatic test_reset_state();
        send_cube(16'sh8000, 16'sh8000, 16'sh8000);
        send_cube(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_cube(16'sh0000, 16'sh0000, 16'sh0000);
    endtask

    // Distances landing exactly on -1/2 stay visible; one LSB below culls.
    task automatic test_half_threshold();
        clear_plan(11'd1);
        plan_coef[CFG_PLANE_LEFT]  = {16'h0000, 16'h0000, 16'h0000, 16'h2000}; // a = 0.5
        plan_coef[CFG_PLANE_RIGHT] = {16'h0000, 16'h0000, 16'h2001, 16'h0000}; // b just over 0.5
        plan_coef[CFG_PLANE_FAR]   = {16'h0000, 16'hC000, 16'h0000, 16'h0000}; // c = -1.0
        apply_setup(1'b0);
        send_cube(-16'sd2, 16'sd0, 16'sd0);
        send_cube(-16'sd3, 16'sd0, 16'sd0);
        send_cube(16'sd0, -16'sd2, 16'sd0);
        send_cube(16'sd0, -16'sd1, 16'sd0);
        send_cube(16'sd0, 16'sd0, 16'sd5);
    endtask

    // Edge of zero tests a point; the wide edges 2047 and 1025 are used as given.
    task automatic test_edge_extremes();
        int edges[3] = '{0, 2047, 1025};
        for (int i = 0; i < 3; i++) begin
            clear_plan(edges[i][EDGE_W-1:0]);
            plan_coef[CFG_PLANE_LEFT] = {16'h0000, 16'h0000, 16'h0000, 16'h4000}; // a = 1.0
            apply_setup(1'b0);
            send_cube(COEF_W'(-(edges[i] + 1)), 16'sd0, 16'sd0);
            send_cube(COEF_W'(-edges[i]), 16'sd0, 16'sd0);
        end
    endtask

    task automatic test_coef_extremes();
        clear_plan(11'd2047);
        plan_coef[CFG_PLANE_LEFT] = 64'h8000_8000_8000_8000;
        apply_setup(1'b0);
        send_cube(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_cube(16'sh8000, 16'sh8000, 16'sh8000);
        plan_coef[CFG_PLANE_LEFT] = 64'h7FFF_7FFF_7FFF_7FFF;
        apply_setup(1'b0);
        send_cube(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_cube(16'sh8000, 16'sh8000, 16'sh8000);
    endtask

    // A write to the spare index must leave every register untouched.
    task automatic test_unused_index();
        clear_plan(EDGE_RESET);
        plan_coef[CFG_PLANE_LEFT] = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
        apply_setup(1'b1);
        send_cube(-16'sd17, 16'sd0, 16'sd0);
        send_cube(-16'sd16, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_stream();
        int active;
        int span;
        logic [EDGE_W-1:0] edge_val;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 6)
                0:       edge_val = 11'd0;
                1:       edge_val = 11'd1;
                2:       edge_val = 11'd1024;
                3:       edge_val = 11'd2047;
                4:       edge_val = EDGE_RESET;
                default: edge_val = EDGE_W'($urandom);
            endcase
            clear_plan(edge_val);
            // Few active planes keep visible and culled results both common.
            active = (ph % 4 == 3) ? NUM_PLANES : int'($urandom_range(1, 3));
            for (int n = 0; n < active; n++)
                plan_coef[$urandom_range(0, NUM_PLANES - 1)] = {$urandom, $urandom};
            apply_setup(1'($urandom_range(0, 1)));
            case (ph % 3)
                0:       span = FULL_SPAN;
                1:       span = 2047;
                default: span = 127;
            endcase
            steady = (ph == 4);
            repeat (ITEMS_PER_PHASE)
                send_cube(pick_coord(span), pick_coord(span), pick_coord(span));
            steady = 1'b0;
        end
    endtask

    initial begin
        for (int p = 0; p < NUM_PLANES; p++)
            plane_coef[p] = '0;
        edge_len = EDGE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_half_threshold();
        test_edge_extremes();
        test_coef_extremes();
        test_unused_index();
        test_random_stream();
        settle_pipeline();
        $display("checked %0d of %0d cubes across %0d plane and edge setups",
                 results_seen, cubes_sent, setups_loaded);
        $display("setups spanned zero, extreme and random planes with edges 0 to 2047");
        if (mismatch_count == 0 && visible_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
